// ----- rtl/cra_pkg.sv -----
// constants shared by the cross-ratio asymmetry datapath
// no dependencies

package cra_pkg;

  localparam int UW       = 31;  // bits of the offset ratio u = c30 + 2^30
  localparam int DQ_W     = 62;  // quotient bits of 2^60 / count
  localparam int DIV_ONE  = 60;  // position of the single set dividend bit
  localparam int S_W      = 63;  // sum of four quotients
  localparam int SQ_STEPS = 32;  // result bits of the square root
  localparam int RT_W     = 64;  // square root remainder
  localparam int D2_W     = 62;  // square of the ratio magnitude
  localparam int F_W      = 59;  // (1 - c^2)/4 in q0.60
  localparam int LO_W     = 32;  // low slice of the factor for the split multiply
  localparam int PROD_W   = 91;  // full error product
  localparam int ERR_SH   = 74;  // shift from product to q0.16
  localparam int OUT_W    = 16;

endpackage

// ----- rtl/cross_ratio_asymmetry.sv -----
// cross-ratio asymmetry and its statistical error for one time bin
// uses cra_pkg for fixed widths of the datapath
// throughput: one item per cycle; a 31-stage ratio search runs beside the
// four constant dividers, then a 32-stage square root and a split multiply
// a stalled output holds the whole pipeline; reset clears the stage valid
// bits and out_valid_o but leaves result_valid_o unchanged

module cross_ratio_asymmetry #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COUNT_WIDTH-1:0] left_first_i,
  input  logic [COUNT_WIDTH-1:0] right_first_i,
  input  logic [COUNT_WIDTH-1:0] left_second_i,
  input  logic [COUNT_WIDTH-1:0] right_second_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   result_valid_o,
  output logic signed [cra_pkg::OUT_W-1:0] cross_ratio_o,
  output logic [cra_pkg::OUT_W-1:0]        ratio_error_o
);
  import cra_pkg::*;

  localparam int W  = COUNT_WIDTH;
  localparam int AW = 2 * W;
  localparam int PW = 2 * UW + 2 * W;
  localparam int LW = UW + 2 * W;
  localparam int SR = UW;

  logic en;

  // ratio search and divider stages
  logic          sr_vld_q  [0:SR];
  logic          sr_zero_q [0:SR];
  logic [UW-1:0] u_q       [0:SR];
  logic [PW-1:0] p_q       [0:SR];
  logic [PW-1:0] q_q       [0:SR];
  logic [LW-1:0] ub_q      [0:SR];
  logic [LW-1:0] va_q      [0:SR];
  logic [AW-1:0] a_q       [0:SR];
  logic [AW-1:0] b_q       [0:SR];
  logic [W-1:0]    cnt_q  [0:SR][0:3];
  logic [W-1:0]    rem_q  [0:SR][0:3];
  logic [DQ_W-1:0] quot_q [0:SR][0:3];

  // square root stages, index 0 loaded after the search
  logic             sq_vld_q  [0:SQ_STEPS];
  logic             sq_zero_q [0:SQ_STEPS];
  logic [OUT_W-1:0] sq_cr_q   [0:SQ_STEPS];
  logic [RT_W-1:0]  sq_rem_q  [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_root_q [0:SQ_STEPS];
  logic [F_W-1:0]   f_q       [1:SQ_STEPS];
  logic [D2_W-1:0]  d2_q;
  logic [D2_W-1:0]  f_diff;

  // split multiply
  logic             m_vld_q, m_zero_q;
  logic [OUT_W-1:0] m_cr_q;
  logic [LO_W+SQ_STEPS-1:0]   m_lo_q;
  logic [F_W-LO_W+SQ_STEPS-1:0] m_hi_q;

  logic             out_vld_q, res_vld_q;
  logic [OUT_W-1:0] cr_q, err_q;

  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  // entry: cross products
  logic [AW-1:0] a_d, b_d;
  assign a_d = AW'(left_second_i) * AW'(right_first_i);
  assign b_d = AW'(left_first_i) * AW'(right_second_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_vld_q[0] <= 1'b0;
    end else if (en) begin
      sr_vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_zero_q[0] <= ~|left_first_i | ~|right_first_i | ~|left_second_i | ~|right_second_i;
      u_q[0]       <= '0;
      p_q[0]       <= '0;
      q_q[0]       <= PW'(a_d) << (2 * UW);
      ub_q[0]      <= '0;
      va_q[0]      <= LW'(a_d) << UW;
      a_q[0]       <= a_d;
      b_q[0]       <= b_d;
      cnt_q[0][0]  <= left_first_i;
      cnt_q[0][1]  <= left_second_i;
      cnt_q[0][2]  <= right_first_i;
      cnt_q[0][3]  <= right_second_i;
      for (int n = 0; n < 4; n++) begin
        rem_q[0][n]  <= '0;
        quot_q[0][n] <= '0;
      end
    end
  end

  for (genvar s = 0; s < SR; s++) begin : g_sr
    localparam int K = SR - 1 - s;
    logic [PW-1:0]   pn, qn;
    logic            take;
    logic [W-1:0]    rem_d  [0:3];
    logic [DQ_W-1:0] quot_d [0:3];

    assign pn   = p_q[s] + (PW'(ub_q[s]) << (K + 1)) + (PW'(b_q[s]) << (2 * K));
    assign qn   = q_q[s] - (PW'(va_q[s]) << (K + 1)) + (PW'(a_q[s]) << (2 * K));
    assign take = pn <= qn;

    always_comb begin
      logic [W-1:0]    rv;
      logic [DQ_W-1:0] qv;
      logic [W:0]      sh;
      for (int n = 0; n < 4; n++) begin
        rv = rem_q[s][n];
        qv = quot_q[s][n];
        for (int j = 0; j < 2; j++) begin
          sh = {rv, ((DQ_W - 1 - 2 * s - j) == DIV_ONE) ? 1'b1 : 1'b0};
          if (sh >= {1'b0, cnt_q[s][n]}) begin
            rv = W'(sh - {1'b0, cnt_q[s][n]});
            qv = {qv[DQ_W-2:0], 1'b1};
          end else begin
            rv = sh[W-1:0];
            qv = {qv[DQ_W-2:0], 1'b0};
          end
        end
        rem_d[n]  = rv;
        quot_d[n] = qv;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_vld_q[s+1] <= 1'b0;
      end else if (en) begin
        sr_vld_q[s+1] <= sr_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_zero_q[s+1] <= sr_zero_q[s];
        a_q[s+1]       <= a_q[s];
        b_q[s+1]       <= b_q[s];
        for (int n = 0; n < 4; n++) begin
          cnt_q[s+1][n]  <= cnt_q[s][n];
          rem_q[s+1][n]  <= rem_d[n];
          quot_q[s+1][n] <= quot_d[n];
        end
        if (take) begin
          u_q[s+1]  <= u_q[s] | (UW'(1) << K);
          p_q[s+1]  <= pn;
          q_q[s+1]  <= qn;
          ub_q[s+1] <= ub_q[s] + (LW'(b_q[s]) << K);
          va_q[s+1] <= va_q[s] - (LW'(a_q[s]) << K);
        end else begin
          u_q[s+1]  <= u_q[s];
          p_q[s+1]  <= p_q[s];
          q_q[s+1]  <= q_q[s];
          ub_q[s+1] <= ub_q[s];
          va_q[s+1] <= va_q[s];
        end
      end
    end
  end

  // magnitude squared, quotient sum, output ratio
  logic [UW-1:0] u_fin, d_mag;
  logic [S_W-1:0] s_sum;
  assign u_fin = u_q[SR];
  assign d_mag = u_fin[UW-1] ? (u_fin - (UW'(1) << (UW - 1)))
                             : ((UW'(1) << (UW - 1)) - u_fin);
  assign s_sum = S_W'(quot_q[SR][0]) + S_W'(quot_q[SR][1])
               + S_W'(quot_q[SR][2]) + S_W'(quot_q[SR][3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= sr_vld_q[SR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_zero_q[0] <= sr_zero_q[SR];
      sq_cr_q[0]   <= u_fin[UW-1:UW-OUT_W] ^ (OUT_W'(1) << (OUT_W - 1));
      sq_rem_q[0]  <= RT_W'(s_sum);
      sq_root_q[0] <= '0;
      d2_q         <= D2_W'(d_mag) * D2_W'(d_mag);
    end
  end

  assign f_diff = (D2_W'(1) << (F_W + 1)) - d2_q;

  for (genvar t = 0; t < SQ_STEPS; t++) begin : g_sq
    localparam int I = SQ_STEPS - 1 - t;
    logic [RT_W-1:0] trial;
    logic            fit;
    logic [F_W-1:0]  f_in;

    assign trial  = (RT_W'(sq_root_q[t]) << (I + 1)) + (RT_W'(1) << (2 * I));
    assign fit    = sq_rem_q[t] >= trial;

    if (t == 0) begin : g_f0
      assign f_in = f_diff[F_W+1:2];
    end else begin : g_fn
      assign f_in = f_q[t];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[t+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[t+1] <= sq_vld_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_zero_q[t+1] <= sq_zero_q[t];
        sq_cr_q[t+1]   <= sq_cr_q[t];
        f_q[t+1]       <= f_in;
        if (fit) begin
          sq_rem_q[t+1]  <= sq_rem_q[t] - trial;
          sq_root_q[t+1] <= sq_root_q[t] | (SQ_STEPS'(1) << I);
        end else begin
          sq_rem_q[t+1]  <= sq_rem_q[t];
          sq_root_q[t+1] <= sq_root_q[t];
        end
      end
    end
  end

  // error product in two halves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= sq_vld_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_zero_q <= sq_zero_q[SQ_STEPS];
      m_cr_q   <= sq_cr_q[SQ_STEPS];
      m_lo_q   <= (LO_W + SQ_STEPS)'(f_q[SQ_STEPS][LO_W-1:0])
                * (LO_W + SQ_STEPS)'(sq_root_q[SQ_STEPS]);
      m_hi_q   <= (F_W - LO_W + SQ_STEPS)'(f_q[SQ_STEPS][F_W-1:LO_W])
                * (F_W - LO_W + SQ_STEPS)'(sq_root_q[SQ_STEPS]);
    end
  end

  logic [PROD_W-1:0] prod;
  logic [PROD_W-ERR_SH-1:0] err_raw;
  logic [OUT_W-1:0] err_sat;
  assign prod    = (PROD_W'(m_hi_q) << LO_W) + PROD_W'(m_lo_q);
  assign err_raw = prod[PROD_W-1:ERR_SH];
  assign err_sat = err_raw[PROD_W-ERR_SH-1] ? '1 : err_raw[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_vld_q <= ~m_zero_q;
      cr_q      <= m_zero_q ? '0 : m_cr_q;
      err_q     <= m_zero_q ? '0 : err_sat;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_valid_o = res_vld_q;
  assign cross_ratio_o  = signed'(cr_q);
  assign ratio_error_o  = err_q;

endmodule
